// File: rtl/timed_tone_controller_macros.svh
// ----------------------------------------------------------------------------
// timed_tone_controller assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_TONE_CONTROLLER_MACROS_SVH
`define TIMED_TONE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define TTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed_tone_controller: same-cycle check failed");

// next-cycle implication
`define TTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timed_tone_controller: next-cycle check failed");

`endif

// File: rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Types and constants shared by the tone controller modules.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int BASE_W = 21;
    localparam int FREQ_W = 16;
    localparam int TIME_W = 32;
    localparam int ACT_W  = 2;
    localparam int DIV_W  = 16;
    localparam int CIDX_W = 2;
    // numerator base + f/2 needs one bit more than base
    localparam int NUM_W  = BASE_W + 1;

    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_BASE_CLOCK = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_FREQ   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_FREQ   = 2'd2;

    localparam logic [BASE_W-1:0] BASE_CLOCK_RST = 21'd1193182;
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST   = 16'd20;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST   = 16'd20000;

    typedef struct packed {
        logic take;
        logic simple;
        logic div_start;
        logic commit;
    } ttc_cmd_t;

    typedef struct packed {
        logic start_ok;
        logic div_done;
    } ttc_sts_t;

endpackage

// File: rtl/timed_tone_controller.sv
// ----------------------------------------------------------------------------
// timed_tone_controller
// Tone generator control with range check, rounded divisor and deadline.
// ----------------------------------------------------------------------------
//  channel  signals                                  direction
//  in       in_valid in_stall action freq_hz dur_ms now_ms   request in
//  out      out_valid out_stall status divisor_load divisor gate_on  result out
//  cfg      cfg_valid cfg_ready cfg_index cfg_data    register write in
//
//  Stop, tick, unused codes and rejected starts: result in the cycle after accept.
//  Accepted start: 22-step restoring divide in S_DIV, then the result on commit in S_COMMIT.
//  One request in flight; the next is taken as the result leaves.
//  Reset: configuration to defaults, tone state off, deadline and stored divisor zero.
//  in_stall rises while a start divides or commits, or a result is held by out_stall.
// ----------------------------------------------------------------------------
`include "timed_tone_controller_macros.svh"

module timed_tone_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ttc_pkg::ACT_W-1:0]     action,
    input  logic [ttc_pkg::FREQ_W-1:0]    freq_hz,
    input  logic [ttc_pkg::TIME_W-1:0]    dur_ms,
    input  logic [ttc_pkg::TIME_W-1:0]    now_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic                          divisor_load,
    output logic [ttc_pkg::DIV_W-1:0]     divisor,
    output logic                          gate_on,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [ttc_pkg::BASE_W-1:0]    cfg_data
);
    import ttc_pkg::*;

    ttc_cmd_t cmd;
    ttc_sts_t sts;

    assign cfg_ready = 1'b1;

    ttc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ttc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .freq_hz      (freq_hz),
        .dur_ms       (dur_ms),
        .now_ms       (now_ms),
        .status       (status),
        .divisor_load (divisor_load),
        .divisor      (divisor),
        .gate_on      (gate_on)
    );

    `TTC_ASSERT_NEXT(a_start_blocks, cmd.div_start, in_stall && !out_valid)
    `TTC_ASSERT_NOW(a_load_gates_on, out_valid && divisor_load, gate_on && !status)
    `TTC_ASSERT_NOW(a_one_result_src, cmd.simple || cmd.commit, !(cmd.simple && cmd.commit))
    `TTC_ASSERT_NEXT(a_commit_result, cmd.commit, out_valid && divisor_load)

endmodule

// File: rtl/ttc_divider.sv
// ----------------------------------------------------------------------------
// ttc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttc_divider #(
    parameter int NUM_W = ttc_pkg::NUM_W,
    parameter int DEN_W = ttc_pkg::FREQ_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/ttc_datapath.sv
// ----------------------------------------------------------------------------
// ttc_datapath
// Configuration, tone state, deadline compare, divisor unit and result regs.
// ----------------------------------------------------------------------------
module ttc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttc_pkg::ttc_cmd_t             cmd,
    output ttc_pkg::ttc_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [ttc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [ttc_pkg::BASE_W-1:0]    cfg_data,
    input  logic [ttc_pkg::ACT_W-1:0]     action,
    input  logic [ttc_pkg::FREQ_W-1:0]    freq_hz,
    input  logic [ttc_pkg::TIME_W-1:0]    dur_ms,
    input  logic [ttc_pkg::TIME_W-1:0]    now_ms,
    output logic                          status,
    output logic                          divisor_load,
    output logic [ttc_pkg::DIV_W-1:0]     divisor,
    output logic                          gate_on
);
    import ttc_pkg::*;

    logic [BASE_W-1:0] base_clock_reg;
    logic [FREQ_W-1:0] min_freq_reg;
    logic [FREQ_W-1:0] max_freq_reg;

    logic              playing_reg, playing_next;
    logic              timed_reg, timed_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic [DIV_W-1:0]  cur_div_reg, cur_div_next;

    logic [FREQ_W-1:0] freq_q_reg;
    logic [TIME_W-1:0] dur_q_reg;
    logic [TIME_W-1:0] now_q_reg;

    logic              status_reg, status_next;
    logic              load_reg, load_next;
    logic [DIV_W-1:0]  div_out_reg, div_out_next;
    logic              gate_reg, gate_next;

    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  quo;
    logic              div_done;
    logic [TIME_W-1:0] tick_diff;
    logic              in_range;

    assign in_range     = (freq_hz >= min_freq_reg) && (freq_hz <= max_freq_reg);
    assign sts.start_ok = (action == ACT_START) && in_range;
    assign sts.div_done = div_done;

    assign num = {1'b0, base_clock_reg} + NUM_W'(freq_hz[FREQ_W-1:1]);

    ttc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (FREQ_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (freq_hz),
        .done  (div_done),
        .quo   (quo)
    );

    assign tick_diff = now_ms - deadline_reg;

    always_comb
    begin
        playing_next  = playing_reg;
        timed_next    = timed_reg;
        deadline_next = deadline_reg;
        cur_div_next  = cur_div_reg;
        status_next   = status_reg;
        load_next     = load_reg;
        div_out_next  = div_out_reg;
        gate_next     = gate_reg;
        if (cmd.simple)
        begin
            case (action)
                ACT_STOP:
                begin
                    playing_next = 1'b0;
                    timed_next   = 1'b0;
                end
                ACT_TICK:
                begin
                    if (playing_reg && timed_reg && !tick_diff[TIME_W-1])
                    begin
                        playing_next = 1'b0;
                        timed_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            // a start that reaches here was rejected
            status_next  = (action == ACT_START);
            load_next    = 1'b0;
            div_out_next = cur_div_reg;
            gate_next    = playing_next;
        end
        else if (cmd.commit)
        begin
            cur_div_next  = (freq_q_reg == '0) ? '0 : quo[DIV_W-1:0];
            timed_next    = (dur_q_reg != '0);
            deadline_next = now_q_reg + dur_q_reg;
            playing_next  = 1'b1;
            status_next   = 1'b0;
            load_next     = 1'b1;
            div_out_next  = cur_div_next;
            gate_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_clock_reg <= BASE_CLOCK_RST;
            min_freq_reg   <= MIN_FREQ_RST;
            max_freq_reg   <= MAX_FREQ_RST;
            playing_reg    <= 1'b0;
            timed_reg      <= 1'b0;
            deadline_reg   <= '0;
            cur_div_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_CLOCK: base_clock_reg <= cfg_data;
                    CFG_MIN_FREQ:   min_freq_reg   <= cfg_data[FREQ_W-1:0];
                    CFG_MAX_FREQ:   max_freq_reg   <= cfg_data[FREQ_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            playing_reg  <= playing_next;
            timed_reg    <= timed_next;
            deadline_reg <= deadline_next;
            cur_div_reg  <= cur_div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            freq_q_reg <= freq_hz;
            dur_q_reg  <= dur_ms;
            now_q_reg  <= now_ms;
        end
        status_reg  <= status_next;
        load_reg    <= load_next;
        div_out_reg <= div_out_next;
        gate_reg    <= gate_next;
    end

    assign status       = status_reg;
    assign divisor_load = load_reg;
    assign divisor      = div_out_reg;
    assign gate_on      = gate_reg;

endmodule

// File: rtl/ttc_ctrl.sv
// ----------------------------------------------------------------------------
// ttc_ctrl
// Request sequencer: accept, divide, commit, and the result valid flag.
// ----------------------------------------------------------------------------
module ttc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ttc_pkg::ttc_sts_t sts,
    output ttc_pkg::ttc_cmd_t cmd
);
    import ttc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIV    = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);

    assign cmd.take      = in_valid && !in_stall;
    assign cmd.simple    = cmd.take && !sts.start_ok;
    assign cmd.div_start = cmd.take && sts.start_ok;
    assign cmd.commit    = (state_reg == S_COMMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.simple || cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
